[hdl/nfcrc_pkg.sv]
// ----------------------------------------------------------------------------
// nfcrc_pkg
// Shared types and constants for the response frame checker.
// ----------------------------------------------------------------------------
package nfcrc_pkg;

  // Default length of the acknowledge frame skipped at the start of a response
  localparam int DEF_ACK_BYTES = 6;

  // Received byte counter, saturating at its all-ones value
  localparam int                 COUNT_W   = 9;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Byte positions relative to the end of the acknowledge frame
  localparam int OFS_LEN    = 3;
  localparam int OFS_LCS    = 4;
  localparam int OFS_TFI    = 5;
  localparam int OFS_STATUS = 7;
  localparam int OFS_MIN    = 9;

  // Checksum complement base
  localparam logic [8:0] CSUM_BASE = 9'h100;

  // Verdict codes
  typedef enum logic [1:0] {
    CHK_OK      = 2'd0,
    CHK_SHORT   = 2'd1,
    CHK_LCS_BAD = 2'd2,
    CHK_DCS_BAD = 2'd3
  } chk_status_t;

  // One input word as held in the input register
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       byte_present;
    logic       end_of_response;
  } item_t;

  // Result word, laid out exactly as out_tdata (lowest field in lowest bits)
  typedef struct packed {
    logic [4:0]  pad;
    logic [7:0]  status_value;
    logic [7:0]  payload_length;
    chk_status_t check_status;
    logic        frame_ok;
  } result_t;

  localparam int OUT_DATA_W = $bits(result_t);

endpackage

[hdl/nfcrc_in_stage.sv]
// ----------------------------------------------------------------------------
// nfcrc_in_stage
// Input register: captures one stream word and holds it until the frame
// tracker takes it.
// ----------------------------------------------------------------------------
module nfcrc_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [7:0]     in_tdata,
  input  logic           in_tuser,
  input  logic           in_tlast,
  input  logic           item_take,
  output logic           item_valid,
  output nfcrc_pkg::item_t item
);
  import nfcrc_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r;

  // Accept a new word whenever the register is empty or drains this cycle
  assign in_tready = !valid_r || item_take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tready) begin
      valid_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Load payload on accept
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.rx_byte         <= in_tdata;
      item_r.byte_present    <= in_tuser;
      item_r.end_of_response <= in_tlast;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

[hdl/nfcrc_tracker.sv]
// ----------------------------------------------------------------------------
// nfcrc_tracker
// Frame state (count, captures, running sum) and the verdict register.
// ----------------------------------------------------------------------------
module nfcrc_tracker #(
  parameter int ACK_BYTES = nfcrc_pkg::DEF_ACK_BYTES
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           item_valid,
  input  nfcrc_pkg::item_t               item,
  output logic                           item_take,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [nfcrc_pkg::OUT_DATA_W-1:0] out_tdata
);
  import nfcrc_pkg::*;

  localparam int POS_W      = COUNT_W + 1;
  localparam int POS_LEN    = ACK_BYTES + OFS_LEN;
  localparam int POS_LCS    = ACK_BYTES + OFS_LCS;
  localparam int POS_TFI    = ACK_BYTES + OFS_TFI;
  localparam int POS_STATUS = ACK_BYTES + OFS_STATUS;
  localparam int MIN_BYTES  = ACK_BYTES + OFS_MIN;

  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [7:0]         len_r, len_nxt;
  logic [7:0]         lcs_r, lcs_nxt;
  logic [7:0]         sum_r, sum_nxt;
  logic [7:0]         dcs_r, dcs_nxt;
  logic [7:0]         stat_r, stat_nxt;
  logic               out_valid_r, out_valid_nxt;
  result_t            result_r, result_nxt;

  logic [POS_W-1:0]   pos;
  logic [POS_W-1:0]   dcs_pos;
  logic               take_byte;
  logic               run_check;
  logic [7:0]         lcs_expect;
  logic [7:0]         dcs_expect;
  chk_status_t        verdict;

  // Take a word unless it carries a verdict and the result register is stuck
  assign item_take = item_valid &&
                     (!item.end_of_response || !out_valid_r || out_tready);
  assign run_check = item_take && item.end_of_response;
  assign take_byte = item_take && item.byte_present && (count_r != COUNT_MAX);

  assign pos     = {1'b0, count_r};
  assign dcs_pos = POS_W'(POS_TFI) + {{(POS_W-8){1'b0}}, len_r};

  // Advance the frame state by one byte
  always_comb begin
    count_nxt = count_r;
    len_nxt   = len_r;
    lcs_nxt   = lcs_r;
    sum_nxt   = sum_r;
    dcs_nxt   = dcs_r;
    stat_nxt  = stat_r;
    if (take_byte) begin
      if (pos == POS_W'(POS_LEN)) begin
        len_nxt = item.rx_byte;
      end
      if (pos == POS_W'(POS_LCS)) begin
        lcs_nxt = item.rx_byte;
      end
      if (pos >= POS_W'(POS_TFI) && pos < dcs_pos) begin
        sum_nxt = sum_r + item.rx_byte;
      end
      if (pos == dcs_pos) begin
        dcs_nxt = item.rx_byte;
      end
      if (pos == POS_W'(POS_STATUS)) begin
        stat_nxt = item.rx_byte;
      end
      count_nxt = count_r + 1'b1;
    end
  end

  // Judge the frame on the updated state, first failing test wins
  assign lcs_expect = 8'(CSUM_BASE - {1'b0, len_nxt});
  assign dcs_expect = 8'(CSUM_BASE - {1'b0, sum_nxt});

  always_comb begin
    if ({1'b0, count_nxt} < POS_W'(MIN_BYTES)) begin
      verdict = CHK_SHORT;
    end else if (lcs_expect != lcs_nxt) begin
      verdict = CHK_LCS_BAD;
    end else if (dcs_expect != dcs_nxt) begin
      verdict = CHK_DCS_BAD;
    end else begin
      verdict = CHK_OK;
    end
  end

  // Hold the result until taken, load a fresh one on a check
  always_comb begin
    out_valid_nxt = out_valid_r;
    result_nxt    = result_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (run_check) begin
      out_valid_nxt             = 1'b1;
      result_nxt.pad            = '0;
      result_nxt.status_value   = stat_nxt;
      result_nxt.payload_length = len_nxt;
      result_nxt.check_status   = verdict;
      result_nxt.frame_ok       = (verdict == CHK_OK);
    end
  end

  // Frame state: clear on reset and after every check
  always_ff @(posedge clk) begin
    if (!rst_n || run_check) begin
      count_r <= '0;
      len_r   <= '0;
      lcs_r   <= '0;
      sum_r   <= '0;
      dcs_r   <= '0;
      stat_r  <= '0;
    end else begin
      count_r <= count_nxt;
      len_r   <= len_nxt;
      lcs_r   <= lcs_nxt;
      sum_r   <= sum_nxt;
      dcs_r   <= dcs_nxt;
      stat_r  <= stat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    result_r <= result_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = result_r;

endmodule

[hdl/nfc_response_frame_checker.sv]
// ----------------------------------------------------------------------------
// nfc_response_frame_checker
// Checks the length and data checksums of one reader response frame.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: one received byte per word. in_tdata carries the byte,
//   in_tuser says whether the byte is real (0 with in_tlast marks a bare end marker) and
//   in_tlast ends the response and triggers the check.
//   The first ACK_BYTES bytes are skipped; LEN, LCS, the sum from TFI on,
//   DCS and the status byte at TFI+2 are captured as the bytes go by.
//   Output stream: one verdict word per response, issued for the word
//   marked in_tlast only; words without in_tlast produce no output.
//   A verdict passes the input register, then the result register.
//   Throughput: one word per cycle while no end word waits for a held
//   verdict to be taken; the count, captures and 8-bit running sum
//   update together for each word.
//   Reset: clears all frame state and the output valid; the block accepts
//   words in the first cycle after reset is released.
//   Stall: a pending verdict holds in the result register; bytes of the
//   next response keep flowing in, and only a further end word waits in
//   the input register, dropping in_tready, until the verdict is taken.
//   After every check all frame state returns to zero.
// ----------------------------------------------------------------------------
module nfc_response_frame_checker #(
  parameter int ACK_BYTES = nfcrc_pkg::DEF_ACK_BYTES
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,   // [7:0] rx_byte
  input  logic                             in_tuser,   // [0] byte_present
  input  logic                             in_tlast,   // end_of_response
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [0] frame_ok, [2:1] check_status, [10:3] payload_length,
  // [18:11] status_value, [23:19] zero
  output logic [nfcrc_pkg::OUT_DATA_W-1:0] out_tdata
);
  import nfcrc_pkg::*;

  logic  item_valid;
  logic  item_take;
  item_t item;

  nfcrc_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .item_take  (item_take),
    .item_valid (item_valid),
    .item       (item)
  );

  nfcrc_tracker #(
    .ACK_BYTES (ACK_BYTES)
  ) u_tracker (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

[hdl/nfcrc_checker.sv]
// ----------------------------------------------------------------------------
// nfcrc_checker
// Port-level checks for the response frame checker, bound to the top level.
// ----------------------------------------------------------------------------
module nfcrc_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [nfcrc_pkg::OUT_DATA_W-1:0] out_tdata
);
  import nfcrc_pkg::*;

  // No verdict right after reset
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // A stalled verdict word holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output word changed");

  // frame_ok agrees with the status code
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[0] == (out_tdata[2:1] == CHK_OK)))
    else $error("frame_ok disagrees with check_status");

  // Padding bits stay zero
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[OUT_DATA_W-1:19] == '0))
    else $error("output padding not zero");

endmodule

bind nfc_response_frame_checker nfcrc_checker u_nfcrc_checker (.*);

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stream-level check of nfc_response_frame_checker.
// A driver feeds response bytes from a queue, a monitor predicts each verdict
// from the accepted words and compares it with the verdict word that comes
// out. Directed frames cover each verdict code and the corner cases; random
// frames, mostly well formed, follow, with random idling on both sides and
// one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import nfcrc_pkg::*;

  localparam int ACK         = DEF_ACK_BYTES;
  localparam int POS_LEN     = ACK + OFS_LEN;
  localparam int POS_LCS     = ACK + OFS_LCS;
  localparam int POS_TFI     = ACK + OFS_TFI;
  localparam int POS_STATUS  = ACK + OFS_STATUS;
  localparam int POS_MIN     = ACK + OFS_MIN;
  localparam int N_RANDOM    = 1500;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYC   = 10;
  localparam int HOLD_AT     = 300;
  localparam int HOLD_CYC    = 300;
  localparam int CALM_TAIL   = 150;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = '0;   // [7:0] rx_byte
  logic                  in_tuser = 1'b0; // [0] byte_present
  logic                  in_tlast = 1'b0; // end_of_response
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // [0] frame_ok, [2:1] check_status, [10:3] payload_length,
  // [18:11] status_value, [23:19] zero
  logic [OUT_DATA_W-1:0] out_tdata;

  nfc_response_frame_checker #(.ACK_BYTES(ACK)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Words waiting to be sent, verdicts waiting to come out
  item_t       pending[$];
  result_t     verdicts[$];
  logic [7:0]  frame_bytes[$];

  int          n_total = 0;
  int          n_accepted = 0;
  int          n_errors = 0;
  int          cycle_cnt = 0;
  bit          in_taken = 1'b0;
  int          send_gap = 0;
  int          stall_cnt = 0;
  int          hold_cnt = 0;
  bit          hold_done = 1'b0;

  // Predicted frame state
  logic [COUNT_W-1:0] rx_count = '0;
  logic [7:0]         len_q = '0;
  logic [7:0]         lcs_q = '0;
  logic [7:0]         sum_q = '0;
  logic [7:0]         dcs_q = '0;
  logic [7:0]         stat_q = '0;

  initial begin
    forever #10 clk = ~clk;
  end

  // Advance the predicted state by one word; return 1 when a verdict is due
  function automatic bit predict_verdict(input item_t w, output result_t res);
    int         pos;
    logic [8:0] lcs_want;
    logic [8:0] dcs_want;
    chk_status_t code;
    pos = int'(rx_count);
    res = '0;
    if (w.byte_present && rx_count != COUNT_MAX) begin
      if (pos == POS_LEN) len_q = w.rx_byte;
      if (pos == POS_LCS) lcs_q = w.rx_byte;
      if (pos >= POS_TFI && pos < POS_TFI + int'(len_q)) sum_q = sum_q + w.rx_byte;
      if (pos == POS_TFI + int'(len_q)) dcs_q = w.rx_byte;
      if (pos == POS_STATUS) stat_q = w.rx_byte;
      rx_count = rx_count + 1'b1;
    end
    if (!w.end_of_response) return 1'b0;
    lcs_want = CSUM_BASE - {1'b0, len_q};
    dcs_want = CSUM_BASE - {1'b0, sum_q};
    if (int'(rx_count) < POS_MIN) code = CHK_SHORT;
    else if (lcs_want[7:0] != lcs_q) code = CHK_LCS_BAD;
    else if (dcs_want[7:0] != dcs_q) code = CHK_DCS_BAD;
    else code = CHK_OK;
    res.frame_ok       = (code == CHK_OK);
    res.check_status   = code;
    res.payload_length = len_q;
    res.status_value   = stat_q;
    // Clear all frame state after every check
    rx_count = '0;
    len_q    = '0;
    lcs_q    = '0;
    sum_q    = '0;
    dcs_q    = '0;
    stat_q   = '0;
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      n_errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, exp_v, act_v);
    end
  endtask

  task automatic push_word(input logic [7:0] b, input bit present, input bit last);
    item_t w;
    w.rx_byte         = b;
    w.byte_present    = present;
    w.end_of_response = last;
    pending.push_back(w);
  endtask

  // Build an information frame behind the acknowledge frame into frame_bytes
  task automatic build_frame(input int len, input bit bad_lcs, input bit bad_dcs,
                             input bit junk_ack);
    logic [7:0] lcs;
    logic [7:0] dcs;
    logic [7:0] sum;
    logic [7:0] b;
    frame_bytes.delete();
    if (junk_ack) begin
      repeat (ACK) frame_bytes.push_back(8'($urandom));
    end else begin
      frame_bytes.push_back(8'h00);
      frame_bytes.push_back(8'h00);
      frame_bytes.push_back(8'hFF);
      frame_bytes.push_back(8'h00);
      frame_bytes.push_back(8'hFF);
      frame_bytes.push_back(8'h00);
    end
    frame_bytes.push_back(8'h00);
    frame_bytes.push_back(8'h00);
    frame_bytes.push_back(8'hFF);
    lcs = 8'(9'h100 - len);
    if (bad_lcs) lcs = lcs ^ 8'($urandom_range(1, 255));
    frame_bytes.push_back(8'(len));
    frame_bytes.push_back(lcs);
    sum = '0;
    for (int i = 0; i < len; i++) begin
      b = (i == 0 && $urandom_range(0, 3) != 0) ? 8'hD5 : 8'($urandom);
      frame_bytes.push_back(b);
      sum = sum + b;
    end
    dcs = 8'(9'h100 - sum);
    if (bad_dcs) dcs = dcs ^ 8'($urandom_range(1, 255));
    frame_bytes.push_back(dcs);
    frame_bytes.push_back(8'h00);
  endtask

  // Send the first keep bytes of frame_bytes, with optional noise words
  task automatic send_frame(input int keep, input bit bare_end, input int noise_pct);
    for (int i = 0; i < keep; i++) begin
      if ($urandom_range(0, 99) < noise_pct) push_word(8'($urandom), 1'b0, 1'b0);
      push_word(frame_bytes[i], 1'b1, !bare_end && (i == keep - 1));
    end
    if (bare_end || keep == 0) push_word(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic fill_stimulus();
    int  len;
    int  keep;
    int  r;
    bit  sat_done;
    sat_done = 1'b0;
    // Bare end marker on an empty response: too short, all zero
    push_word(8'hFF, 1'b0, 1'b1);
    // Ignored word, then a short response with extreme bytes
    push_word(8'hFF, 1'b0, 1'b0);
    push_word(8'hFF, 1'b1, 1'b0);
    push_word(8'h00, 1'b1, 1'b1);
    // Good frame, LCS bad, DCS bad
    build_frame(3, 1'b0, 1'b0, 1'b0);
    send_frame(frame_bytes.size(), 1'b0, 0);
    build_frame(3, 1'b1, 1'b0, 1'b0);
    send_frame(frame_bytes.size(), 1'b1, 0);
    build_frame(3, 1'b0, 1'b1, 1'b0);
    send_frame(frame_bytes.size(), 1'b0, 0);
    // Long LEN cut off before DCS: missing DCS reads as zero
    build_frame(40, 1'b0, 1'b0, 1'b0);
    send_frame(POS_MIN + 1, 1'b0, 0);

    while (pending.size() < N_RANDOM) begin
      r = $urandom_range(0, 99);
      if (!sat_done && pending.size() >= 800) begin
        // Overlong response: count saturates, further bytes dropped
        sat_done = 1'b1;
        build_frame(5, 1'b0, 1'b0, 1'b0);
        while (frame_bytes.size() < 530) frame_bytes.push_back(8'($urandom));
        send_frame(frame_bytes.size(), $urandom_range(0, 1) == 1, 5);
      end else if (r < 75) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 12);
        build_frame(len, $urandom_range(0, 19) == 0, $urandom_range(0, 19) == 0,
                    $urandom_range(0, 4) == 0);
        keep = ($urandom_range(0, 6) == 0) ? $urandom_range(0, frame_bytes.size())
                                           : frame_bytes.size();
        send_frame(keep, $urandom_range(0, 4) == 0, 10);
      end else begin
        // Random garbage response
        frame_bytes.delete();
        repeat ($urandom_range(0, 30)) frame_bytes.push_back(8'($urandom));
        send_frame(frame_bytes.size(), $urandom_range(0, 1) == 1, 20);
      end
    end
  endtask

  // Drive: hold a word until taken, then load the next or idle
  always @(negedge clk) begin
    item_t w;
    if (rst_n) begin
      if (!in_tvalid || in_taken) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (pending.size() > 0) begin
          w = pending.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= w.rx_byte;
          in_tuser  <= w.byte_present;
          in_tlast  <= w.end_of_response;
          if ((n_total - n_accepted) > CALM_TAIL && $urandom_range(0, 7) == 0)
            send_gap = $urandom_range(1, 9);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receive: random stalls plus one long hold-off to back up the block
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_tready <= 1'b0;
      end else if (!hold_done && n_accepted >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_cnt  = HOLD_CYC - 1;
        out_tready <= 1'b0;
      end else if (stall_cnt > 0) begin
        stall_cnt--;
        out_tready <= 1'b0;
      end else if ((n_total - n_accepted) > CALM_TAIL && $urandom_range(0, 9) == 0) begin
        stall_cnt = $urandom_range(0, 8);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Monitor: check verdict words, then predict from accepted input words
  always @(posedge clk) begin
    result_t exp_r;
    result_t got_r;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got_r = result_t'(out_tdata);
        if (verdicts.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected verdict word, expected none, actual %h",
                   $realtime, out_tdata);
        end else begin
          exp_r = verdicts.pop_front();
          check_field("frame_ok", exp_r.frame_ok, got_r.frame_ok);
          check_field("check_status", exp_r.check_status, got_r.check_status);
          check_field("payload_length", exp_r.payload_length, got_r.payload_length);
          check_field("status_value", exp_r.status_value, got_r.status_value);
          check_field("pad", exp_r.pad, got_r.pad);
        end
      end
      in_taken = in_tvalid && in_tready;
      if (in_taken) begin
        n_accepted++;
        if (predict_verdict({in_tdata, in_tuser, in_tlast}, exp_r)) verdicts.push_back(exp_r);
      end
    end else begin
      in_taken = 1'b0;
    end
  end

  // Cycle limit
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("%0t: timeout after %0d cycles", $realtime, cycle_cnt);
    $display("CHECKS FAILED");
    $finish;
  end

  // Sequence the run: fill, reset, drain, verdict
  initial begin
    fill_stimulus();
    n_total = pending.size();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    while (n_accepted < n_total) @(negedge clk);
    while (verdicts.size() != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);
    if (n_errors == 0 && verdicts.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[nfc_response_frame_checker.f]
hdl/nfcrc_pkg.sv
hdl/nfcrc_in_stage.sv
hdl/nfcrc_tracker.sv
hdl/nfc_response_frame_checker.sv
hdl/nfcrc_checker.sv
tb/testbench.sv
